// ===== rtl/keyframe_track_sampler_unit_defines.svh =====
// assertion macros for the keyframe track sampler
// used by files that check their own control logic; expects clk_i and rst_ni in scope
`ifndef KEYFRAME_TRACK_SAMPLER_UNIT_DEFINES_SVH
`define KEYFRAME_TRACK_SAMPLER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define KTSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KTSU_ASSERT_NEXT(lbl, pre, post, msg) \
  `KTSU_ASSERT(lbl, (pre) |=> (post), msg)
`else
`define KTSU_ASSERT(lbl, prop, msg)
`define KTSU_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/ktsu_pkg.sv =====
// shared types, codes and helpers of the keyframe track sampler
// no dependencies
package ktsu_pkg;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_RESTART = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;

  localparam logic [1:0] CFG_TRACK_TYPE = 2'd0;
  localparam logic [1:0] CFG_KEY_COUNT  = 2'd1;
  localparam logic [1:0] CFG_LOOP       = 2'd2;
  localparam logic [1:0] CFG_AUTO_PLAY  = 2'd3;

  localparam logic [2:0] TYPE_QUAT = 3'd4;

  localparam int NUM_LANES = 4;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         key_index;
    logic [31:0]        key_time;
    logic signed [31:0] in_comp_0;
    logic signed [31:0] in_comp_1;
    logic signed [31:0] in_comp_2;
    logic signed [31:0] in_comp_3;
    logic [31:0]        delta_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_comp_0;
    logic signed [31:0] out_comp_1;
    logic signed [31:0] out_comp_2;
    logic signed [31:0] out_comp_3;
    logic [2:0]         component_count;
    logic [31:0]        sample_time;
    logic               past_end;
  } out_item_t;

  typedef struct packed {
    logic blend;
    logic norm;
  } lane_ctl_t;

  function automatic logic [2:0] comp_count(input logic [2:0] ttype);
    logic [2:0] n;
    if (ttype >= 3'd1 && ttype <= 3'd3) begin
      n = ttype + 3'd1;
    end else if (ttype == TYPE_QUAT) begin
      n = 3'd4;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

endpackage

// ===== rtl/ktsu_stream_if.sv =====
// valid/ready stream channel carrying one payload item
// payload type is set by the instantiating level
interface ktsu_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ktsu_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module ktsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/ktsu_div.sv =====
// restoring divider, one quotient bit per cycle
// no dependencies; done_o pulses when quotient and remainder are ready
module ktsu_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [NW-1:0] quot_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   trial;
  logic          take;

  assign trial = {rem_q, quot_q[NW-1]};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(NW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - CW'(1);
        done_q <= cnt_q == CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (cnt_q != '0) begin
      quot_q <= {quot_q[NW-2:0], take};
      rem_q  <= take ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

// ===== rtl/ktsu_lane.sv =====
// one component lane: linear blend, square for the norm, normalizing divide
// depends on ktsu_pkg and ktsu_div
module ktsu_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ktsu_pkg::lane_ctl_t ctl_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  input  logic [16:0]         r_i,
  input  logic [32:0]         norm_i,
  output logic signed [31:0]  res_o,
  output logic [63:0]         sq_o,
  output logic                done_o
);
  logic [16:0]        w0;
  logic signed [49:0] p0_q, p1_q;
  logic signed [50:0] x;
  logic signed [31:0] res_q;
  logic [31:0]        mag_q;
  logic [31:0]        mag_d;
  logic               neg_q;
  logic [63:0]        sq_q;
  logic               st1_q, st2_q, done_q;
  logic               div_done;
  logic [48:0]        div_quot;
  logic [32:0]        div_rem;
  logic [48:0]        div_num;

  assign w0 = 17'd65536 - r_i;
  assign x  = {p0_q[49], p0_q} + {p1_q[49], p1_q} + 51'sd32768;
  assign div_num = {1'b0, mag_q, 16'b0} + {16'b0, norm_i[32:1]};
  // magnitude as unsigned, so the most negative value squares correctly
  assign mag_d = res_q[31] ? 32'(-res_q) : 32'(res_q);

  ktsu_div #(.NW(49), .DW(33)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.norm),
    .num_i   (div_num),
    .den_i   (norm_i),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_q  <= 1'b0;
      st2_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      st1_q  <= ctl_i.blend;
      st2_q  <= st1_q;
      done_q <= st2_q || div_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.blend) begin
      p0_q <= a_i * $signed({1'b0, w0});
      p1_q <= b_i * $signed({1'b0, r_i});
    end
    if (st1_q) begin
      // floor of the biased sum over 65536
      res_q <= x[47:16];
    end
    if (st2_q) begin
      neg_q <= res_q[31];
      mag_q <= mag_d;
      sq_q  <= 64'(mag_d) * 64'(mag_d);
    end
    if (div_done) begin
      res_q <= neg_q ? -$signed(div_quot[31:0]) : $signed(div_quot[31:0]);
    end
  end

  assign res_o  = res_q;
  assign sq_o   = sq_q;
  assign done_o = done_q && (div_rem == div_rem);
endmodule

// ===== rtl/ktsu_norm.sv =====
// merging stage: sum of lane squares and bit-serial integer square root
// no dependencies; an overflowing sum gives a norm of 2^32
module ktsu_norm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] sq0_i,
  input  logic [63:0] sq1_i,
  input  logic [63:0] sq2_i,
  input  logic [63:0] sq3_i,
  output logic        done_o,
  output logic [32:0] norm_o
);
  logic [64:0] sum;
  logic [63:0] n_q, res_q, bit_q;
  logic        carry_q;
  logic [5:0]  cnt_q;
  logic        done_q;
  logic [63:0] trial;

  assign sum   = 65'(sq0_i) + 65'(sq1_i) + 65'(sq2_i) + 65'(sq3_i);
  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= 6'd32;
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 6'd1;
        done_q <= cnt_q == 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q     <= sum[63:0];
      carry_q <= sum[64];
      res_q   <= '0;
      bit_q   <= 64'd1 << 62;
    end else if (cnt_q != '0) begin
      if (n_q >= trial) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign norm_o = carry_q ? 33'h1_0000_0000 : res_q[32:0];
endmodule

// ===== rtl/keyframe_track_sampler_unit.sv =====
// Keyframe track sampler. Load and restart requests complete as they are accepted. A tick
// while playing reads the last key time, then scans key times one per cycle from the time
// memory until a key at or after the play time is found. Between two keys a serial divider
// forms the blend ratio, four component lanes blend, and quaternion tracks add a square root
// and a lane divide. A looping advance past the track end reuses the serial divider. The
// result register lets the next request enter while a result waits.
// depends on ktsu_pkg, ktsu_stream_if, ktsu_ram, ktsu_div, ktsu_lane, ktsu_norm
`include "keyframe_track_sampler_unit_defines.svh"
module keyframe_track_sampler_unit #(
  parameter int MAX_KEYS    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  ktsu_stream_if.sink   in_i,
  ktsu_stream_if.source out_o
);
  localparam int AW = $clog2(MAX_KEYS);
  localparam int VW = VALUE_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_LEN, S_SCAN0, S_SCAN, S_VA, S_VB, S_VC, S_RDIV,
    S_BLEND, S_SQ, S_NDIV, S_RAW, S_RAW1, S_ADV, S_MOD, S_OUT
  } state_e;

  state_e state_q;

  logic [2:0]  track_type_q;
  logic [6:0]  key_count_q;
  logic        loop_q, auto_q;
  logic [31:0] play_time_q, delta_q, len_q, prev_t_q, nxt_pt_q;
  logic        playing_q, past_q;
  logic [AW-1:0] idx_q, vaddr_q, cnt_m1, traddr;
  logic signed [31:0] a_q [4];
  logic signed [31:0] b_q [4];
  logic signed [31:0] res_q [4];
  logic        out_valid_q;
  ktsu_pkg::out_item_t out_q;

  logic        in_acc, load_we;
  logic [31:0] trdata;
  logic [4*VW-1:0] vrdata, vwdata;
  logic [32:0] t_sum;
  logic        hit;

  logic        div_start, div_done;
  logic [47:0] div_num, div_quot;
  logic [31:0] div_den, div_rem;

  ktsu_pkg::lane_ctl_t lane_ctl;
  logic signed [31:0] lane_res [4];
  logic [63:0] lane_sq [4];
  logic [3:0]  lane_done;
  logic        norm_start, norm_done;
  logic [32:0] norm;
  logic [2:0]  ncomp;

  assign in_acc  = in_i.valid && in_i.ready;
  assign load_we = in_acc && in_i.data.func == ktsu_pkg::FUNC_LOAD &&
                   32'(in_i.data.key_index) < MAX_KEYS;
  assign in_i.ready  = state_q == S_IDLE;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    if (key_count_q == 7'd0) begin
      cnt_m1 = '0;
    end else if (32'(key_count_q) > MAX_KEYS) begin
      cnt_m1 = AW'(MAX_KEYS - 1);
    end else begin
      cnt_m1 = AW'(32'(key_count_q) - 32'd1);
    end
  end

  always_comb begin
    unique case (state_q)
      S_LEN:   traddr = cnt_m1;
      S_SCAN0: traddr = '0;
      default: traddr = idx_q + AW'(1);
    endcase
  end

  assign vwdata = {in_i.data.in_comp_3[VW-1:0], in_i.data.in_comp_2[VW-1:0],
                   in_i.data.in_comp_1[VW-1:0], in_i.data.in_comp_0[VW-1:0]};

  ktsu_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(32'(in_i.data.key_index))),
    .wdata_i (in_i.data.key_time),
    .raddr_i (traddr),
    .rdata_o (trdata)
  );

  ktsu_ram #(.WIDTH(4*VW), .DEPTH(MAX_KEYS)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(32'(in_i.data.key_index))),
    .wdata_i (vwdata),
    .raddr_i (vaddr_q),
    .rdata_o (vrdata)
  );

  assign hit   = trdata >= play_time_q;
  assign t_sum = {1'b0, play_time_q} + {1'b0, delta_q};

  // divider is shared by the blend ratio and the looping wrap
  assign div_start = (state_q == S_SCAN && hit && idx_q != '0) ||
                     (state_q == S_ADV && loop_q && len_q != '0 && t_sum > {1'b0, len_q});
  assign div_num = (state_q == S_ADV) ? 48'(t_sum) : {play_time_q - prev_t_q, 16'b0};
  assign div_den = (state_q == S_ADV) ? len_q : trdata - prev_t_q;

  ktsu_div #(.NW(48), .DW(32)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  assign lane_ctl.blend = state_q == S_RDIV && div_done;
  assign lane_ctl.norm  = state_q == S_SQ && norm_done && norm != '0;

  // the ratio goes straight from the divider into the lanes as they start
  for (genvar k = 0; k < ktsu_pkg::NUM_LANES; k++) begin : g_lane
    ktsu_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl),
      .a_i    (a_q[k]),
      .b_i    (b_q[k]),
      .r_i    (div_quot[16:0]),
      .norm_i (norm),
      .res_o  (lane_res[k]),
      .sq_o   (lane_sq[k]),
      .done_o (lane_done[k])
    );
  end

  assign norm_start = state_q == S_BLEND && lane_done == 4'hF &&
                      track_type_q == ktsu_pkg::TYPE_QUAT;

  ktsu_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .sq0_i   (lane_sq[0]),
    .sq1_i   (lane_sq[1]),
    .sq2_i   (lane_sq[2]),
    .sq3_i   (lane_sq[3]),
    .done_o  (norm_done),
    .norm_o  (norm)
  );

  assign ncomp = ktsu_pkg::comp_count(track_type_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      track_type_q <= 3'd0;
      key_count_q  <= 7'd1;
      loop_q       <= 1'b0;
      auto_q       <= 1'b1;
      play_time_q  <= '0;
      playing_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
      past_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ktsu_pkg::CFG_TRACK_TYPE: track_type_q <= cfg_data_i[2:0];
          ktsu_pkg::CFG_KEY_COUNT:  key_count_q  <= cfg_data_i;
          ktsu_pkg::CFG_LOOP:       loop_q       <= cfg_data_i[0];
          ktsu_pkg::CFG_AUTO_PLAY:  auto_q       <= cfg_data_i[0];
          default: ;
        endcase
      end
      // a result leaving in the output state is replaced there
      if (out_o.valid && out_o.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_i.data.func == ktsu_pkg::FUNC_RESTART) begin
              play_time_q <= '0;
              playing_q   <= auto_q;
            end else if (in_i.data.func == ktsu_pkg::FUNC_TICK && playing_q) begin
              delta_q <= in_i.data.delta_time;
              past_q  <= 1'b0;
              idx_q   <= '0;
              state_q <= S_LEN;
            end
          end
        end
        S_LEN: state_q <= S_SCAN0;
        S_SCAN0: begin
          len_q   <= trdata;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            if (idx_q == '0) begin
              vaddr_q <= '0;
              state_q <= S_RAW;
            end else begin
              vaddr_q <= idx_q - AW'(1);
              state_q <= S_VA;
            end
          end else if (idx_q == cnt_m1) begin
            past_q  <= 1'b1;
            vaddr_q <= cnt_m1;
            state_q <= S_RAW;
          end else begin
            prev_t_q <= trdata;
            idx_q    <= idx_q + AW'(1);
          end
        end
        S_VA: begin
          vaddr_q <= idx_q;
          state_q <= S_VB;
        end
        S_VB: begin
          for (int k = 0; k < 4; k++) begin
            a_q[k] <= 32'($signed(vrdata[k*VW +: VW]));
          end
          state_q <= S_VC;
        end
        S_VC: begin
          for (int k = 0; k < 4; k++) begin
            b_q[k] <= 32'($signed(vrdata[k*VW +: VW]));
          end
          state_q <= S_RDIV;
        end
        S_RDIV: begin
          if (div_done) begin
            state_q <= S_BLEND;
          end
        end
        S_BLEND: begin
          if (lane_done == 4'hF) begin
            for (int k = 0; k < 4; k++) begin
              res_q[k] <= lane_res[k];
            end
            state_q <= (track_type_q == ktsu_pkg::TYPE_QUAT) ? S_SQ : S_ADV;
          end
        end
        S_SQ: begin
          if (norm_done) begin
            // zero norm keeps the zero vector
            state_q <= (norm == '0) ? S_ADV : S_NDIV;
          end
        end
        S_NDIV: begin
          if (lane_done == 4'hF) begin
            for (int k = 0; k < 4; k++) begin
              res_q[k] <= lane_res[k];
            end
            state_q <= S_ADV;
          end
        end
        S_RAW: state_q <= S_RAW1;
        S_RAW1: begin
          for (int k = 0; k < 4; k++) begin
            res_q[k] <= 32'($signed(vrdata[k*VW +: VW]));
          end
          state_q <= S_ADV;
        end
        S_ADV: begin
          if (loop_q) begin
            if (len_q == '0) begin
              nxt_pt_q <= '0;
              state_q  <= S_OUT;
            end else if (t_sum > {1'b0, len_q}) begin
              state_q <= S_MOD;
            end else begin
              nxt_pt_q <= t_sum[31:0];
              state_q  <= S_OUT;
            end
          end else begin
            nxt_pt_q <= t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
            state_q  <= S_OUT;
          end
        end
        S_MOD: begin
          if (div_done) begin
            nxt_pt_q <= (div_rem == '0) ? len_q : div_rem;
            state_q  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_q.out_comp_0      <= res_q[0];
            out_q.out_comp_1      <= (ncomp > 3'd1) ? res_q[1] : 32'sd0;
            out_q.out_comp_2      <= (ncomp > 3'd2) ? res_q[2] : 32'sd0;
            out_q.out_comp_3      <= (ncomp > 3'd3) ? res_q[3] : 32'sd0;
            out_q.component_count <= ncomp;
            out_q.sample_time     <= play_time_q;
            out_q.past_end        <= past_q;
            out_valid_q           <= 1'b1;
            play_time_q           <= nxt_pt_q;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `KTSU_ASSERT(a_ratio_range, (state_q == S_RDIV && div_done) |-> (div_quot <= 48'd65536), "blend ratio above one")
  `KTSU_ASSERT_NEXT(a_playing_held, state_q != S_IDLE, $stable(playing_q), "playing changed during a tick")
  `KTSU_ASSERT(a_norm_quat, (state_q == S_SQ) |-> (track_type_q == ktsu_pkg::TYPE_QUAT), "norm on non-quaternion track")
  `KTSU_ASSERT(a_lanes_lockstep, (lane_done != 4'h0) |-> (lane_done == 4'hF), "lanes out of step")
endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for keyframe_track_sampler_unit: loads tracks, restarts and ticks,
// predicts each sample and compares it field by field
// depends on ktsu_pkg, ktsu_stream_if and the sampler rtl
`timescale 1ns / 1ps
module tb_top;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = ktsu_pkg::CFG_TRACK_TYPE;
  logic [6:0] cfg_data_i = '0;

  ktsu_stream_if #(.T(ktsu_pkg::in_item_t)) req_if ();
  ktsu_stream_if #(.T(ktsu_pkg::out_item_t)) smp_if ();

  keyframe_track_sampler_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(req_if.sink), .out_o(smp_if.source)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [31:0] trk_time [64];
  logic signed [63:0] trk_val [64][4];
  logic [31:0] play_t;
  bit playing;
  logic [2:0] ttype;
  logic [6:0] nkeys;
  bit loop_on, autoplay;

  ktsu_pkg::out_item_t sample_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  // a toggle of hold_req starts one long receiver hold
  bit hold_req = 0;
  bit hold_seen = 0;
  int hold_cnt = 0;

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] mix(input logic signed [63:0] a,
                                             input logic signed [63:0] b,
                                             input logic [63:0] r);
    logic signed [63:0] x;
    logic [63:0] bias;
    x = a * $signed(64'd65536 - r) + b * $signed(r);
    bias = x + 64'sd32768 + (64'sd1 <<< 48);
    return $signed(bias >> 16) - (64'sd1 <<< 32);
  endfunction

  task automatic predict_tick(input logic [31:0] dt);
    logic signed [63:0] c [4];
    logic [63:0] m, sum, prev, norm, qv, t, r, t0, t1;
    logic [31:0] len;
    int cnt, i, k, ncomp;
    bit found, past, carry;
    ktsu_pkg::out_item_t o;
    if (!playing) return;
    cnt = (nkeys == 0) ? 1 : (nkeys > 64 ? 64 : nkeys);
    ncomp = ktsu_pkg::comp_count(ttype);
    len = trk_time[cnt-1];
    found = 0;
    past = 0;
    for (i = 0; i < cnt; i++) if (trk_time[i] >= play_t) begin found = 1; break; end
    if (!found) begin
      past = 1;
      for (k = 0; k < 4; k++) c[k] = trk_val[cnt-1][k];
    end else if (i == 0) begin
      for (k = 0; k < 4; k++) c[k] = trk_val[0][k];
    end else begin
      t0 = trk_time[i-1];
      t1 = trk_time[i];
      r = ((64'(play_t) - t0) << 16) / (t1 - t0);
      for (k = 0; k < 4; k++) c[k] = mix(trk_val[i-1][k], trk_val[i][k], r);
      if (ttype == ktsu_pkg::TYPE_QUAT) begin
        sum = 0;
        carry = 0;
        for (k = 0; k < 4; k++) begin
          m = c[k] < 0 ? -c[k] : c[k];
          prev = sum;
          sum += m * m;
          if (sum < prev) carry = 1;
        end
        norm = carry ? 64'd1 << 32 : isqrt(sum);
        if (norm != 0) begin
          for (k = 0; k < 4; k++) begin
            m = c[k] < 0 ? -c[k] : c[k];
            qv = ((m << 16) + (norm >> 1)) / norm;
            c[k] = c[k] < 0 ? -$signed(qv) : $signed(qv);
          end
        end
      end
    end
    o.out_comp_0 = c[0][31:0];
    o.out_comp_1 = ncomp > 1 ? c[1][31:0] : 32'd0;
    o.out_comp_2 = ncomp > 2 ? c[2][31:0] : 32'd0;
    o.out_comp_3 = ncomp > 3 ? c[3][31:0] : 32'd0;
    o.component_count = 3'(ncomp);
    o.sample_time = play_t;
    o.past_end = past;
    sample_q.push_back(o);
    t = 64'(play_t) + 64'(dt);
    if (loop_on) begin
      if (len == 0) t = 0;
      else if (t > len) begin
        t = t % len;
        if (t == 0) t = len;
      end
    end else if (t > 64'hFFFF_FFFF) begin
      t = 64'hFFFF_FFFF;
    end
    play_t = t[31:0];
  endtask

  task automatic predict(input ktsu_pkg::in_item_t it);
    case (it.func)
      ktsu_pkg::FUNC_LOAD: begin
        trk_time[it.key_index] = it.key_time;
        trk_val[it.key_index][0] = it.in_comp_0;
        trk_val[it.key_index][1] = it.in_comp_1;
        trk_val[it.key_index][2] = it.in_comp_2;
        trk_val[it.key_index][3] = it.in_comp_3;
      end
      ktsu_pkg::FUNC_RESTART: begin
        play_t = 0;
        playing = autoplay;
      end
      ktsu_pkg::FUNC_TICK: predict_tick(it.delta_time);
      default: ;
    endcase
  endtask

  // valid stays up after a request until the next one, an idle cycle or a drain
  task automatic send_item(input ktsu_pkg::in_item_t it);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= it;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict(it);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      ktsu_pkg::CFG_TRACK_TYPE: ttype = val[2:0];
      ktsu_pkg::CFG_KEY_COUNT: nkeys = val;
      ktsu_pkg::CFG_LOOP: loop_on = val[0];
      default: autoplay = val[0];
    endcase
  endtask

  // waits until every sample is back, then lets a slow tick drain
  task automatic drain;
    req_if.valid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic setup(input logic [2:0] ty, input logic [6:0] n, input bit lp, input bit ap);
    drain();
    write_reg(ktsu_pkg::CFG_TRACK_TYPE, 7'(ty));
    write_reg(ktsu_pkg::CFG_KEY_COUNT, n);
    write_reg(ktsu_pkg::CFG_LOOP, 7'(lp));
    write_reg(ktsu_pkg::CFG_AUTO_PLAY, 7'(ap));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_comp(input bit wide);
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      default: return wide ? $urandom() : 32'($signed($urandom_range(262144)) - 131072);
    endcase
  endfunction

  task automatic load_key(input int idx, input logic [31:0] kt, input bit wide);
    ktsu_pkg::in_item_t it;
    it = '0;
    it.func = ktsu_pkg::FUNC_LOAD;
    it.key_index = 6'(idx);
    it.key_time = kt;
    it.in_comp_0 = rnd_comp(wide);
    it.in_comp_1 = rnd_comp(wide);
    it.in_comp_2 = rnd_comp(wide);
    it.in_comp_3 = rnd_comp(wide);
    it.delta_time = $urandom();
    send_item(it);
  endtask

  // non-decreasing key times over n keys, spacing random
  task automatic load_track(input int n, input bit wide, input logic [31:0] step_max);
    logic [63:0] kt;
    int i;
    kt = $urandom_range(3) == 0 ? 64'd0 : 64'($urandom_range(step_max));
    for (i = 0; i < n; i++) begin
      load_key(i, kt[31:0], wide);
      kt = kt + ($urandom_range(7) == 0 ? 64'd0 : 64'($urandom_range(step_max, 1)));
      if (kt > 64'hFFFF_FFFF) kt = 64'hFFFF_FFFF;
    end
  endtask

  task automatic send_cmd(input logic [1:0] f, input logic [31:0] dt);
    ktsu_pkg::in_item_t it;
    it.func = f;
    it.key_index = 6'($urandom());
    it.key_time = $urandom();
    it.in_comp_0 = $urandom();
    it.in_comp_1 = $urandom();
    it.in_comp_2 = $urandom();
    it.in_comp_3 = $urandom();
    it.delta_time = dt;
    send_item(it);
  endtask

  task automatic test_directed;
    ktsu_pkg::in_item_t it;
    setup(3'd3, 7'd2, 0, 1);
    it = '0;
    it.func = ktsu_pkg::FUNC_LOAD;
    it.key_time = 32'd0;
    it.in_comp_0 = 32'sh7FFF_FFFF;
    it.in_comp_1 = 32'sh8000_0000;
    it.in_comp_2 = 32'sh7FFF_FFFF;
    it.in_comp_3 = 32'sh8000_0000;
    send_item(it);
    it.key_index = 6'd1;
    it.key_time = 32'hFFFF_FFFF;
    it.in_comp_0 = 32'sh8000_0000;
    it.in_comp_1 = 32'sh7FFF_FFFF;
    it.in_comp_2 = 32'sh8000_0000;
    it.in_comp_3 = 32'sh7FFF_FFFF;
    send_item(it);
    send_cmd(ktsu_pkg::FUNC_TICK, 32'd5);           // not playing yet: dropped
    send_cmd(2'd3, 32'd0);                          // undefined func: dropped
    send_cmd(ktsu_pkg::FUNC_RESTART, 32'd0);
    send_cmd(ktsu_pkg::FUNC_TICK, 32'h8000_0000);   // key zero
    send_cmd(ktsu_pkg::FUNC_TICK, 32'hFFFF_FFFF);   // midpoint, then saturate
    send_cmd(ktsu_pkg::FUNC_TICK, 32'd0);           // exactly on last key
    // zero-length looping quaternion with two all-zero keys
    setup(ktsu_pkg::TYPE_QUAT, 7'd2, 1, 1);
    it = '0;
    it.func = ktsu_pkg::FUNC_LOAD;
    send_item(it);
    it.key_index = 6'd1;
    send_item(it);
    send_cmd(ktsu_pkg::FUNC_RESTART, 32'd0);
    send_cmd(ktsu_pkg::FUNC_TICK, 32'd100);
    send_cmd(ktsu_pkg::FUNC_TICK, 32'd100);
    // past the end, bad type and key count extremes
    setup(3'd7, 7'd0, 0, 1);
    load_key(0, 32'd10, 1);
    send_cmd(ktsu_pkg::FUNC_RESTART, 32'd0);
    send_cmd(ktsu_pkg::FUNC_TICK, 32'd20);
    send_cmd(ktsu_pkg::FUNC_TICK, 32'd1);
    setup(3'd5, 7'd127, 0, 0);
    send_cmd(ktsu_pkg::FUNC_RESTART, 32'd0);
    send_cmd(ktsu_pkg::FUNC_TICK, 32'd1);           // auto play off: dropped
  endtask

  task automatic test_random(input int n_items);
    int done, nk, j;
    logic [2:0] ty;
    logic [6:0] kc;
    done = 0;
    while (done < n_items) begin
      ty = $urandom_range(99) < 10 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      nk = $urandom_range(19) == 0 ? 64 : $urandom_range(8, 1);
      kc = $urandom_range(15) == 0 ? 7'($urandom_range(127, 65)) : 7'(nk);
      setup(ty, kc, 1'($urandom_range(1)), $urandom_range(7) != 0);
      // every key in use is loaded
      if (kc > 7'd64 || $urandom_range(15) == 0) nk = 64;
      load_track(nk, $urandom_range(3) == 0, $urandom_range(1) ? 32'h0004_0000 : 32'h0FFF_FFFF);
      done += nk;
      send_cmd(ktsu_pkg::FUNC_RESTART, 32'd0);
      for (j = 0; j < 20; j++) begin
        case ($urandom_range(19))
          0: send_cmd(ktsu_pkg::FUNC_RESTART, 32'd0);
          1: send_cmd(2'd3, $urandom());
          2: load_key($urandom_range(nk - 1), trk_time[$urandom_range(nk - 1)], 1);
          3: send_cmd(ktsu_pkg::FUNC_TICK, $urandom());
          default: send_cmd(ktsu_pkg::FUNC_TICK, $urandom_range(32'h0003_0000));
        endcase
        done++;
      end
    end
  endtask

  task automatic test_backpressure;
    int j;
    setup(3'd0, 7'd2, 1, 1);
    load_track(2, 0, 32'h0002_0000);
    send_cmd(ktsu_pkg::FUNC_RESTART, 32'd0);
    hold_req = !hold_req;
    for (j = 0; j < 12; j++) send_cmd(ktsu_pkg::FUNC_TICK, $urandom_range(32'h0001_0000));
  endtask

  // sample checker
  always @(posedge clk_i) begin
    if (rst_ni && smp_if.valid && smp_if.ready) begin
      if (sample_q.size() == 0) begin
        $display("%0t sample with none expected: %p", $realtime, smp_if.data);
        errors++;
      end else begin
        ktsu_pkg::out_item_t e;
        e = sample_q.pop_front();
        if (e.out_comp_0 !== smp_if.data.out_comp_0 || e.out_comp_1 !== smp_if.data.out_comp_1
            || e.out_comp_2 !== smp_if.data.out_comp_2
            || e.out_comp_3 !== smp_if.data.out_comp_3
            || e.component_count !== smp_if.data.component_count
            || e.sample_time !== smp_if.data.sample_time
            || e.past_end !== smp_if.data.past_end) begin
          $display("%0t sample mismatch: expected %p actual %p", $realtime, e, smp_if.data);
          errors++;
        end
      end
    end
  end

  // receiver stall, with a long hold counted here when asked
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_if.ready <= 1'b0;
      hold_seen <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= 400;
      smp_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      smp_if.ready <= 1'b0;
    end else begin
      smp_if.ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    play_t = 0;
    playing = 0;
    ttype = 0;
    nkeys = 1;
    loop_on = 0;
    autoplay = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 26;
    recv_idle = 77;
    test_directed();
    test_random(480);
    test_backpressure();
    send_idle = 77;
    recv_idle = 26;
    test_random(480);
    send_idle = 0;
    recv_idle = 0;
    test_random(480);
    drain();
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ktsu_pkg.sv
rtl/ktsu_stream_if.sv
rtl/ktsu_ram.sv
rtl/ktsu_div.sv
rtl/ktsu_lane.sv
rtl/ktsu_norm.sv
rtl/keyframe_track_sampler_unit.sv
sim/tb_top.sv
